// File: design/bpsp_pkg.sv
// Shared types, widths and constants for the box and plane section block.
// Used by every module of the block; depends on nothing.
`default_nettype none
package bpsp_pkg;

  localparam int COORD_W     = 32;
  localparam int NORM_W      = 18;
  localparam int PROD_W      = NORM_W + COORD_W;
  localparam int DIST_W      = 51;
  localparam int DIV_W       = 52;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int RATIO_W     = 16;
  localparam int COL_W       = 17;
  localparam int NUM_CORNERS = 8;
  localparam int NUM_EDGES   = 12;
  localparam int MAX_PTS     = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COL_W-1:0] RATIO_ONE = COL_W'(65536);
  localparam logic signed [NORM_W-1:0] NZ_RESET = NORM_W'(65536);

  typedef enum logic [2:0] {
    REG_NX     = 3'd0,
    REG_NY     = 3'd1,
    REG_NZ     = 3'd2,
    REG_OFFSET = 3'd3
  } reg_index_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIST_W-1:0] dist_t;

  typedef struct packed {
    coord_t [2:0] s;
    coord_t [2:0] e;
    dist_t [NUM_CORNERS-1:0] d;
    logic skip;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [2:0] edge_p(input logic [3:0] idx);
    logic [2:0] r;
    case (idx)
      4'd0, 4'd1, 4'd4: r = 3'd0;
      4'd2, 4'd5:       r = 3'd1;
      4'd3, 4'd6:       r = 3'd2;
      4'd7:             r = 3'd3;
      4'd8, 4'd9:       r = 3'd4;
      4'd10:            r = 3'd5;
      4'd11:            r = 3'd6;
      default:          r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] edge_q(input logic [3:0] idx);
    logic [2:0] r;
    case (idx)
      4'd0:              r = 3'd1;
      4'd1:              r = 3'd2;
      4'd2, 4'd3:        r = 3'd3;
      4'd4:              r = 3'd4;
      4'd5, 4'd8:        r = 3'd5;
      4'd6, 4'd9:        r = 3'd6;
      4'd7, 4'd10, 4'd11: r = 3'd7;
      default:           r = 3'd1;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/bpsp_front.sv
// Front end: takes a box request and works out the plane distance of its eight corners.
// Depends on bpsp_pkg; hands finished jobs to bpsp_queue.
`default_nettype none
module bpsp_front import bpsp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] box_start_x,
  input  logic signed [COORD_W-1:0] box_start_y,
  input  logic signed [COORD_W-1:0] box_start_z,
  input  logic signed [COORD_W-1:0] box_end_x,
  input  logic signed [COORD_W-1:0] box_end_y,
  input  logic signed [COORD_W-1:0] box_end_z,
  input  logic                      skip_box,
  input  logic signed [NORM_W-1:0]  nx,
  input  logic signed [NORM_W-1:0]  ny,
  input  logic signed [NORM_W-1:0]  nz,
  input  logic signed [COORD_W-1:0] offset,
  input  q_stat_t                   qstat,
  output logic                      push,
  output job_t                      job
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CALC = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t fs;
  logic [3:0] ci;
  logic [2:0] pc;
  logic pv;
  logic signed [PROD_W-1:0] pr0, pr1, pr2;
  logic signed [COORD_W-1:0] cx, cy, cz;
  logic signed [DIST_W-1:0] offs;

  assign cx = ci[0] ? $signed(job.e[0]) : $signed(job.s[0]);
  assign cy = ci[1] ? $signed(job.e[1]) : $signed(job.s[1]);
  assign cz = ci[2] ? $signed(job.e[2]) : $signed(job.s[2]);
  assign offs = DIST_W'($signed({offset, 16'b0}));

  assign busy = (fs != F_IDLE);
  assign push = (fs == F_PUSH) && !qstat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fs <= F_IDLE;
      pv <= 1'b0;
      ci <= '0;
    end else begin
      case (fs)
        F_IDLE: begin
          pv <= 1'b0;
          if (start) begin
            job.s[0] <= box_start_x;
            job.s[1] <= box_start_y;
            job.s[2] <= box_start_z;
            job.e[0] <= box_end_x;
            job.e[1] <= box_end_y;
            job.e[2] <= box_end_z;
            job.skip <= skip_box;
            ci <= '0;
            fs <= skip_box ? F_PUSH : F_CALC;
          end
        end
        F_CALC: begin
          pr0 <= nx * cx;
          pr1 <= ny * cy;
          pr2 <= nz * cz;
          pc <= ci[2:0];
          pv <= (ci < 4'(NUM_CORNERS));
          if (pv) begin
            job.d[pc] <= DIST_W'(pr0) + DIST_W'(pr1) + DIST_W'(pr2) + offs;
          end
          ci <= ci + 4'd1;
          if (ci == 4'(NUM_CORNERS)) begin
            fs <= F_PUSH;
          end
        end
        F_PUSH: begin
          pv <= 1'b0;
          if (!qstat.full) begin
            fs <= F_IDLE;
          end
        end
        default: fs <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/bpsp_queue.sv
// Short job queue between the distance front end and the section back end.
// Depends on bpsp_pkg for the job record.
`default_nettype none
module bpsp_queue import bpsp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  job_t    job_in,
  input  logic    pop,
  output job_t    job_out,
  output q_stat_t qstat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0] count;

  assign job_out = mem[rptr];
  assign qstat.full = (count == (AW+1)'(DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        mem[wptr] <= job_in;
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/bpsp_cmp.sv
// Orientation test: sign of u . (v x n) with one shared multiplier.
// Depends on bpsp_pkg; used by bpsp_back for the vertex sort.
`default_nettype none
module bpsp_cmp import bpsp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic signed [DIFF_W-1:0] u [3],
  input  logic signed [DIFF_W-1:0] v [3],
  input  logic signed [NORM_W-1:0] n [3],
  output logic                     done,
  output logic                     lt
);

  localparam int W_W    = 52;
  localparam int WL_W   = 26;
  localparam int MB_W   = 27;
  localparam int MP_W   = DIFF_W + MB_W;
  localparam int ACC_W  = 88;
  localparam int SC_GAP = 6;
  localparam int SC_END = 12;
  localparam int SC_LAST = 14;

  logic act, pv;
  logic [3:0] sc, pstep;
  logic signed [W_W-1:0] w [3];
  logic signed [ACC_W-1:0] acc;
  logic signed [MP_W-1:0] prod;
  logic signed [DIFF_W-1:0] ma;
  logic signed [MB_W-1:0] mb;

  always_comb begin
    ma = '0;
    mb = '0;
    case (sc)
      4'd0:  begin ma = v[1]; mb = MB_W'(n[2]); end
      4'd1:  begin ma = v[2]; mb = MB_W'(n[1]); end
      4'd2:  begin ma = v[2]; mb = MB_W'(n[0]); end
      4'd3:  begin ma = v[0]; mb = MB_W'(n[2]); end
      4'd4:  begin ma = v[0]; mb = MB_W'(n[1]); end
      4'd5:  begin ma = v[1]; mb = MB_W'(n[0]); end
      4'd7:  begin ma = u[0]; mb = MB_W'($signed(w[0][W_W-1:WL_W])); end
      4'd8:  begin ma = u[0]; mb = $signed({1'b0, w[0][WL_W-1:0]}); end
      4'd9:  begin ma = u[1]; mb = MB_W'($signed(w[1][W_W-1:WL_W])); end
      4'd10: begin ma = u[1]; mb = $signed({1'b0, w[1][WL_W-1:0]}); end
      4'd11: begin ma = u[2]; mb = MB_W'($signed(w[2][W_W-1:WL_W])); end
      4'd12: begin ma = u[2]; mb = $signed({1'b0, w[2][WL_W-1:0]}); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign done = act && (sc == 4'(SC_LAST));
  assign lt = acc[ACC_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
      pv <= 1'b0;
      sc <= '0;
    end else if (go) begin
      act <= 1'b1;
      pv <= 1'b0;
      sc <= '0;
      acc <= '0;
      for (int k = 0; k < 3; k++) begin
        w[k] <= '0;
      end
    end else if (act) begin
      prod <= ma * mb;
      pstep <= sc;
      pv <= (sc != 4'(SC_GAP)) && (sc <= 4'(SC_END));
      sc <= sc + 4'd1;
      if (done) begin
        act <= 1'b0;
      end
      if (pv) begin
        case (pstep)
          4'd0:  w[0] <= w[0] + W_W'(prod);
          4'd1:  w[0] <= w[0] - W_W'(prod);
          4'd2:  w[1] <= w[1] + W_W'(prod);
          4'd3:  w[1] <= w[1] - W_W'(prod);
          4'd4:  w[2] <= w[2] + W_W'(prod);
          4'd5:  w[2] <= w[2] - W_W'(prod);
          4'd7, 4'd9, 4'd11: acc <= acc + (ACC_W'(prod) <<< WL_W);
          4'd8, 4'd10, 4'd12: acc <= acc + ACC_W'(prod);
          default: acc <= acc;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// File: design/bpsp_back.sv
// Back end: finds crossing edges, interpolates vertices, sorts them and sends the results.
// Depends on bpsp_pkg and bpsp_cmp; takes jobs from bpsp_queue.
`default_nettype none
module bpsp_back import bpsp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  job_t                      job_in,
  input  q_stat_t                   qstat,
  output logic                      pop,
  input  logic signed [NORM_W-1:0]  nx,
  input  logic signed [NORM_W-1:0]  ny,
  input  logic signed [NORM_W-1:0]  nz,
  output logic                      valid,
  output logic signed [COORD_W-1:0] point_x,
  output logic signed [COORD_W-1:0] point_y,
  output logic signed [COORD_W-1:0] point_z,
  output logic [COL_W-1:0]          color_r,
  output logic [COL_W-1:0]          color_g,
  output logic [COL_W-1:0]          color_b,
  output logic [2:0]                point_index,
  output logic [2:0]                point_count,
  output logic                      last
);

  localparam int PM_W = DIFF_W + RATIO_W + 1;

  typedef enum logic [12:0] {
    B_IDLE  = 13'b0000000000001,
    B_SCAN  = 13'b0000000000010,
    B_SCAN2 = 13'b0000000000100,
    B_DIV   = 13'b0000000001000,
    B_MUL   = 13'b0000000010000,
    B_ADD   = 13'b0000000100000,
    B_FIN   = 13'b0000001000000,
    B_LOADU = 13'b0000010000000,
    B_LOADV = 13'b0000100000000,
    B_CMP   = 13'b0001000000000,
    B_PLACE = 13'b0010000000000,
    B_OUT   = 13'b0100000000000,
    B_EMPTY = 13'b1000000000000
  } bstate_t;

  bstate_t bs;
  job_t jb;
  logic [2:0] cnt, i, j, k, t, pp, pq, ord_addr, ord_rd;
  logic [3:0] edg;
  logic [4:0] dstep;
  logic [2:0] ord [MAX_PTS];
  logic signed [COORD_W-1:0] ptc [MAX_PTS][3];
  logic [COL_W-1:0] ptl [MAX_PTS][3];
  logic signed [DIST_W-1:0] da, d_rd, dn, dp;
  logic [DIV_W-1:0] r, den, r2, num;
  logic [RATIO_W-1:0] lq;
  logic signed [PM_W-1:0] m [3];
  logic signed [DIFF_W-1:0] u [3];
  logic signed [DIFF_W-1:0] v [3];
  logic signed [NORM_W-1:0] nv [3];
  logic [NUM_CORNERS-1:0] dneg, dpos;
  logic [2:0] ep, eq, d_addr;
  logic cross_e, cmp_go, cmp_done, cmp_lt;

  function automatic logic signed [COORD_W-1:0] corner_at(input job_t jj, input logic [2:0] c,
                                                          input int kk);
    return c[kk] ? $signed(jj.e[kk]) : $signed(jj.s[kk]);
  endfunction

  assign nv[0] = nx;
  assign nv[1] = ny;
  assign nv[2] = nz;

  assign ep = edge_p(edg);
  assign eq = edge_q(edg);
  assign d_addr = (bs == B_SCAN2) ? eq : ep;
  assign d_rd = $signed(jb.d[d_addr]);

  always_comb begin
    for (int c = 0; c < NUM_CORNERS; c++) begin
      dneg[c] = jb.d[c][DIST_W-1];
      dpos[c] = !jb.d[c][DIST_W-1] && (jb.d[c] != '0);
    end
  end
  assign cross_e = (dneg[ep] && dpos[eq]) || (dpos[ep] && dneg[eq]);

  assign dn = da[DIST_W-1] ? da : d_rd;
  assign dp = da[DIST_W-1] ? d_rd : da;
  assign num = DIV_W'(-DIV_W'(dn));
  assign r2 = {r[DIV_W-2:0], 1'b0};

  always_comb begin
    case (bs)
      B_LOADV, B_CMP: ord_addr = j - 3'd1;
      B_OUT:          ord_addr = k;
      default:        ord_addr = i;
    endcase
  end
  assign ord_rd = ord[ord_addr];

  assign pop = (bs == B_IDLE) && !qstat.empty;
  assign cmp_go = (bs == B_LOADV) && (j > 3'd1);

  bpsp_cmp u_cmp (
    .clk  (clk),
    .rst  (rst),
    .go   (cmp_go),
    .u    (u),
    .v    (v),
    .n    (nv),
    .done (cmp_done),
    .lt   (cmp_lt)
  );

  always_ff @(posedge clk) begin
    logic signed [DIFF_W-1:0] diff;
    logic [PM_W-1:0] magu;
    logic [PM_W-1:0] qv;
    logic signed [DIFF_W-1:0] dl;
    logic signed [DIFF_W-1:0] sum;
    if (rst) begin
      bs <= B_IDLE;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (bs)
        B_IDLE: begin
          if (!qstat.empty) begin
            jb <= job_in;
            cnt <= '0;
            edg <= '0;
            for (int c = 0; c < MAX_PTS; c++) begin
              ord[c] <= 3'(c);
            end
            bs <= job_in.skip ? B_EMPTY : B_SCAN;
          end
        end
        B_SCAN: begin
          if (cross_e && (cnt < 3'(MAX_PTS))) begin
            da <= d_rd;
            bs <= B_SCAN2;
          end else if (edg == 4'(NUM_EDGES-1)) begin
            bs <= B_FIN;
          end else begin
            edg <= edg + 4'd1;
          end
        end
        B_SCAN2: begin
          pp <= da[DIST_W-1] ? ep : eq;
          pq <= da[DIST_W-1] ? eq : ep;
          r <= num;
          den <= num + DIV_W'(dp);
          lq <= '0;
          dstep <= '0;
          bs <= B_DIV;
        end
        B_DIV: begin
          if (r2 >= den) begin
            r <= r2 - den;
            lq <= {lq[RATIO_W-2:0], 1'b1};
          end else begin
            r <= r2;
            lq <= {lq[RATIO_W-2:0], 1'b0};
          end
          dstep <= dstep + 5'd1;
          if (dstep == 5'(RATIO_W-1)) begin
            bs <= B_MUL;
          end
        end
        B_MUL: begin
          for (int kk = 0; kk < 3; kk++) begin
            diff = DIFF_W'(corner_at(jb, pq, kk)) - DIFF_W'(corner_at(jb, pp, kk));
            m[kk] <= diff * $signed({1'b0, lq});
          end
          bs <= B_ADD;
        end
        B_ADD: begin
          for (int kk = 0; kk < 3; kk++) begin
            magu = m[kk][PM_W-1] ? PM_W'(-m[kk]) : PM_W'(m[kk]);
            qv = magu >> RATIO_W;
            dl = m[kk][PM_W-1] ? -$signed(DIFF_W'(qv)) : $signed(DIFF_W'(qv));
            sum = DIFF_W'(corner_at(jb, pp, kk)) + dl;
            ptc[cnt][kk] <= sum[COORD_W-1:0];
            if (pp[kk] == pq[kk]) begin
              ptl[cnt][kk] <= pp[kk] ? RATIO_ONE : '0;
            end else if (pq[kk]) begin
              ptl[cnt][kk] <= {1'b0, lq};
            end else begin
              ptl[cnt][kk] <= RATIO_ONE - {1'b0, lq};
            end
          end
          cnt <= cnt + 3'd1;
          if (edg == 4'(NUM_EDGES-1)) begin
            bs <= B_FIN;
          end else begin
            edg <= edg + 4'd1;
            bs <= B_SCAN;
          end
        end
        B_FIN: begin
          i <= 3'd2;
          bs <= (cnt < 3'd3) ? B_EMPTY : B_LOADU;
        end
        B_LOADU: begin
          t <= ord_rd;
          j <= i;
          for (int kk = 0; kk < 3; kk++) begin
            u[kk] <= DIFF_W'(ptc[ord_rd][kk]) - DIFF_W'(ptc[0][kk]);
          end
          bs <= B_LOADV;
        end
        B_LOADV: begin
          if (j > 3'd1) begin
            for (int kk = 0; kk < 3; kk++) begin
              v[kk] <= DIFF_W'(ptc[ord_rd][kk]) - DIFF_W'(ptc[0][kk]);
            end
            bs <= B_CMP;
          end else begin
            bs <= B_PLACE;
          end
        end
        B_CMP: begin
          if (cmp_done) begin
            if (cmp_lt) begin
              ord[j] <= ord_rd;
              j <= j - 3'd1;
              bs <= B_LOADV;
            end else begin
              bs <= B_PLACE;
            end
          end
        end
        B_PLACE: begin
          ord[j] <= t;
          if (i == cnt - 3'd1) begin
            k <= '0;
            bs <= B_OUT;
          end else begin
            i <= i + 3'd1;
            bs <= B_LOADU;
          end
        end
        B_OUT: begin
          valid <= 1'b1;
          point_x <= ptc[ord_rd][0];
          point_y <= ptc[ord_rd][1];
          point_z <= ptc[ord_rd][2];
          color_r <= ptl[ord_rd][0];
          color_g <= ptl[ord_rd][1];
          color_b <= ptl[ord_rd][2];
          point_index <= k;
          point_count <= cnt;
          last <= (k == cnt - 3'd1);
          if (k == cnt - 3'd1) begin
            bs <= B_IDLE;
          end else begin
            k <= k + 3'd1;
          end
        end
        B_EMPTY: begin
          valid <= 1'b1;
          point_x <= '0;
          point_y <= '0;
          point_z <= '0;
          color_r <= '0;
          color_g <= '0;
          color_b <= '0;
          point_index <= '0;
          point_count <= '0;
          last <= 1'b1;
          bs <= B_IDLE;
        end
        default: bs <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/box_plane_section_polygon.sv
// Top level of the box and plane section block: plane registers, front end, queue, back end.
// Depends on bpsp_pkg, bpsp_front, bpsp_queue and bpsp_back.
//
// A box request is taken at a clock edge where start is high and busy is low. The front
// end works out the corner distances (three multipliers, one corner a cycle) and parks
// the job in a short queue; busy stays high until the job is in the queue, longer while
// the queue is full.
// The back end then scans the box edges and works out each crossing edge's ratio with
// a bit-serial divider. Three or more vertices are sorted by insertion, each orientation
// test running on one shared multiplier.
// Results come one per cycle, each marked by valid for exactly one cycle; last marks the
// final result of a request, and a request without a section gives one result with
// point_count zero. The receiver cannot hold results off.
// The user must write the plane registers through wr_en, wr_index and wr_data only while
// idle; the block does not enforce this. An index beyond the offset register is ignored.
// Synchronous reset empties the queue, returns both ends to idle and loads the plane z = 0.
`default_nettype none
module box_plane_section_polygon import bpsp_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] box_start_x,
  input  logic signed [COORD_W-1:0] box_start_y,
  input  logic signed [COORD_W-1:0] box_start_z,
  input  logic signed [COORD_W-1:0] box_end_x,
  input  logic signed [COORD_W-1:0] box_end_y,
  input  logic signed [COORD_W-1:0] box_end_z,
  input  logic                      skip_box,
  input  logic                      wr_en,
  input  logic [2:0]                wr_index,
  input  logic [COORD_W-1:0]        wr_data,
  output logic                      valid,
  output logic signed [COORD_W-1:0] point_x,
  output logic signed [COORD_W-1:0] point_y,
  output logic signed [COORD_W-1:0] point_z,
  output logic [COL_W-1:0]          color_r,
  output logic [COL_W-1:0]          color_g,
  output logic [COL_W-1:0]          color_b,
  output logic [2:0]                point_index,
  output logic [2:0]                point_count,
  output logic                      last
);

  logic signed [NORM_W-1:0] plane_nx, plane_ny, plane_nz;
  logic signed [COORD_W-1:0] plane_offset;
  logic push, pop;
  job_t job_f, job_q;
  q_stat_t qstat;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_nx <= '0;
      plane_ny <= '0;
      plane_nz <= NZ_RESET;
      plane_offset <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_NX:     plane_nx <= wr_data[NORM_W-1:0];
        REG_NY:     plane_ny <= wr_data[NORM_W-1:0];
        REG_NZ:     plane_nz <= wr_data[NORM_W-1:0];
        REG_OFFSET: plane_offset <= wr_data;
        default:    plane_offset <= plane_offset;
      endcase
    end
  end

  bpsp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .box_start_x (box_start_x),
    .box_start_y (box_start_y),
    .box_start_z (box_start_z),
    .box_end_x   (box_end_x),
    .box_end_y   (box_end_y),
    .box_end_z   (box_end_z),
    .skip_box    (skip_box),
    .nx          (plane_nx),
    .ny          (plane_ny),
    .nz          (plane_nz),
    .offset      (plane_offset),
    .qstat       (qstat),
    .push        (push),
    .job         (job_f)
  );

  bpsp_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .job_in  (job_f),
    .pop     (pop),
    .job_out (job_q),
    .qstat   (qstat)
  );

  bpsp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_in      (job_q),
    .qstat       (qstat),
    .pop         (pop),
    .nx          (plane_nx),
    .ny          (plane_ny),
    .nz          (plane_nz),
    .valid       (valid),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .color_r     (color_r),
    .color_g     (color_g),
    .color_b     (color_b),
    .point_index (point_index),
    .point_count (point_count),
    .last        (last)
  );

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    valid && (point_count == 3'd0) |-> last)
    else $error("empty section result not marked last");

  a_polygon_contiguous: assert property (@(posedge clk) disable iff (rst)
    valid && !last |=> valid)
    else $error("gap inside the results of one request");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    valid && (point_count != 3'd0) |-> (point_index < point_count))
    else $error("vertex index beyond vertex count");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("front end idle right after taking a request");

endmodule
`default_nettype wire

// File: bench/tb_box_plane_section_polygon.sv
// Self-checking testbench for box_plane_section_polygon: directed boxes, then random boxes
// under several plane settings, each result checked against one predicted in the bench.
// Depends on bpsp_pkg and the RTL of the block only.
`timescale 1ns / 100ps
module tb_box_plane_section_polygon;
  import bpsp_pkg::*;

  localparam int LIMIT = 1000000;
  localparam logic [2:0] IDX_UNUSED = 3'd7;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [31:0] sx, sy, sz, ex, ey, ez;
    logic skip;
    logic want_empty;
  } box_t;

  typedef struct packed {
    logic signed [31:0] x, y, z;
    logic [16:0] r, g, b;
    logic [2:0] idx, cnt;
    logic last;
  } vertex_t;

  typedef struct {
    longint c[3];
    int unsigned col[3];
  } pt_t;

  logic clk = 0, rst = 1, start = 0, skip_box = 0, wr_en = 0;
  logic [2:0] wr_index = 0;
  logic [31:0] wr_data = 0;
  logic signed [31:0] box_start_x = 0, box_start_y = 0, box_start_z = 0;
  logic signed [31:0] box_end_x = 0, box_end_y = 0, box_end_z = 0;
  logic busy, valid, last;
  logic signed [31:0] point_x, point_y, point_z;
  logic [16:0] color_r, color_g, color_b;
  logic [2:0] point_index, point_count;

  logic signed [17:0] plane_n[3];
  logic signed [31:0] plane_off;
  vertex_t section_q[$];
  int errors = 0;
  int cycles = 0;
  box_t dir_tab[10];

  box_plane_section_polygon dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic bit ahead_of(pt_t a, pt_t b, pt_t o);
    longint u[3], v[3], w[3];
    wide_t acc;
    for (int k = 0; k < 3; k++) begin
      u[k] = a.c[k] - o.c[k];
      v[k] = b.c[k] - o.c[k];
    end
    w[0] = v[1] * plane_n[2] - v[2] * plane_n[1];
    w[1] = v[2] * plane_n[0] - v[0] * plane_n[2];
    w[2] = v[0] * plane_n[1] - v[1] * plane_n[0];
    acc = wide_t'(u[0]) * wide_t'(w[0]) + wide_t'(u[1]) * wide_t'(w[1])
        + wide_t'(u[2]) * wide_t'(w[2]);
    return acc < 0;
  endfunction

  function automatic void predict_section(box_t b);
    longint s[3], e[3], crn[8][3], d[8], nn[3];
    pt_t pts[6], tmp;
    int cnt, p, q, j;
    logic [127:0] num, den, lq;
    longint prod;
    vertex_t v;
    cnt = 0;
    s = '{b.sx, b.sy, b.sz};
    e = '{b.ex, b.ey, b.ez};
    for (int k = 0; k < 3; k++) nn[k] = plane_n[k];
    if (!b.skip) begin
      for (int i = 0; i < 8; i++) begin
        d[i] = longint'(plane_off) * 65536;
        for (int k = 0; k < 3; k++) begin
          crn[i][k] = ((i >> k) & 1) ? e[k] : s[k];
          d[i] += nn[k] * crn[i][k];
        end
      end
      for (int i = 0; i < NUM_EDGES; i++) begin
        p = edge_p(4'(i));
        q = edge_q(4'(i));
        if (!((d[p] < 0 && d[q] > 0) || (d[p] > 0 && d[q] < 0)) || cnt >= 6) continue;
        if (d[p] > 0) begin
          j = p; p = q; q = j;
        end
        num = 128'(-d[p]);
        den = num + 128'(d[q]);
        lq = (num << 16) / den;
        for (int k = 0; k < 3; k++) begin
          prod = (crn[q][k] - crn[p][k]) * longint'(lq[15:0]);
          pts[cnt].c[k] = crn[p][k] + prod / 65536;
          if (((p >> k) & 1) == ((q >> k) & 1)) pts[cnt].col[k] = ((p >> k) & 1) ? 65536 : 0;
          else if ((q >> k) & 1) pts[cnt].col[k] = lq[15:0];
          else pts[cnt].col[k] = 65536 - lq[15:0];
        end
        cnt++;
      end
    end
    if (cnt < 3) begin
      v = '0;
      v.last = 1;
      section_q.push_back(v);
      return;
    end
    for (int i = 2; i < cnt; i++) begin
      tmp = pts[i];
      j = i;
      while (j > 1 && ahead_of(tmp, pts[j-1], pts[0])) begin
        pts[j] = pts[j-1];
        j--;
      end
      pts[j] = tmp;
    end
    for (int i = 0; i < cnt; i++) begin
      v.x = pts[i].c[0];
      v.y = pts[i].c[1];
      v.z = pts[i].c[2];
      v.r = pts[i].col[0];
      v.g = pts[i].col[1];
      v.b = pts[i].col[2];
      v.idx = i;
      v.cnt = cnt;
      v.last = (i == cnt - 1);
      section_q.push_back(v);
    end
  endfunction

  always @(posedge clk) begin
    vertex_t got, want;
    got = '{point_x, point_y, point_z, color_r, color_g, color_b, point_index, point_count, last};
    if (!rst && valid) begin
      if (section_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result: %p", got);
      end else begin
        want = section_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // The request is held until an edge at which busy is low.
  task automatic issue(box_t b);
    start <= 1;
    box_start_x <= b.sx;
    box_start_y <= b.sy;
    box_start_z <= b.sz;
    box_end_x <= b.ex;
    box_end_y <= b.ey;
    box_end_z <= b.ez;
    skip_box <= b.skip;
    do @(posedge clk); while (busy);
    if (b.want_empty) section_q.push_back('{default: '0, last: 1'b1});
    else predict_section(b);
  endtask

  task automatic gap(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    while (section_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_plane(int nx, int ny, int nz, int off);
    int vals[4];
    vals = '{nx, ny, nz, off};
    for (int i = 0; i < 4; i++) begin
      wr_en <= 1;
      wr_index <= i;
      wr_data <= vals[i];
      @(posedge clk);
    end
    wr_index <= IDX_UNUSED;
    wr_data <= $urandom;
    @(posedge clk);
    wr_en <= 0;
    plane_n[0] = nx;
    plane_n[1] = ny;
    plane_n[2] = nz;
    plane_off = off;
  endtask

  function automatic box_t random_box();
    box_t b;
    int sel, c, h;
    b = '0;
    sel = $urandom_range(99);
    if (sel < 12) begin
      {b.sx, b.sy, b.sz, b.ex, b.ey, b.ez} = {$urandom, $urandom, $urandom,
                                               $urandom, $urandom, $urandom};
      b.skip = (sel < 5);
      return b;
    end
    for (int k = 0; k < 3; k++) begin
      c = int'($urandom_range(0, 1 << 22)) - (1 << 21);
      h = (sel < 18 && k == $urandom_range(2)) ? 0 : int'($urandom_range(1 << 20));
      if ($urandom_range(9) == 0) h = -h;
      case (k)
        0: begin b.sx = c - h; b.ex = c + h; end
        1: begin b.sy = c - h; b.ey = c + h; end
        default: begin b.sz = c - h; b.ez = c + h; end
      endcase
    end
    return b;
  endfunction

  function automatic int rnd_norm();
    return int'($urandom_range(131072)) - 65536;
  endfunction

  function automatic int rnd_off();
    return int'($urandom_range(1 << 21)) - (1 << 20);
  endfunction

  initial begin
    int planes[6][4];
    plane_n = '{18'sd0, 18'sd0, 18'sd65536};
    plane_off = 0;
    dir_tab[0] = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1, 1'b1};
    dir_tab[1] = '{32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 1'b1};
    dir_tab[2] = '{0, 0, 65536, 65536, 65536, 131072, 1'b0, 1'b1};
    dir_tab[3] = '{-65536, -65536, -65536, 65536, 65536, 65536, 1'b0, 1'b0};
    dir_tab[4] = '{65536, 65536, 65536, -65536, -65536, -65536, 1'b0, 1'b0};
    dir_tab[5] = '{-65536, -65536, 0, 65536, 65536, 0, 1'b0, 1'b1};
    dir_tab[6] = '{5, -65536, -65536, 5, 65536, 65536, 1'b0, 1'b0};
    dir_tab[7] = '{32'h80000000, 32'h80000000, 32'h80000000,
                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, 1'b0};
    dir_tab[8] = '{0, 0, -65536, 65536, 65536, 0, 1'b0, 1'b1};
    dir_tab[9] = '{-3, 7, -1, 9, -2, 1, 1'b0, 1'b0};
    planes[0] = '{-65536, 0, 0, 32'h7fffffff};
    planes[1] = '{65536, 65536, 65536, 32'h80000000};
    planes[2] = '{37837, 37837, 37837, rnd_off()};
    planes[3] = '{rnd_norm(), rnd_norm(), rnd_norm(), rnd_off()};
    planes[4] = '{-37837, 37837, -37837, rnd_off()};
    planes[5] = '{rnd_norm(), rnd_norm(), rnd_norm(), rnd_off()};

    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      gap(30);
      issue(dir_tab[i]);
    end
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_plane(planes[ph][0], planes[ph][1], planes[ph][2], planes[ph][3]);
      for (int n = 0; n < 70; n++) begin
        gap(ph < 2 ? 18 : (ph < 4 ? 69 : 0));
        issue(random_box());
      end
      drain();
    end

    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: files.f
design/bpsp_pkg.sv
design/bpsp_front.sv
design/bpsp_queue.sv
design/bpsp_cmp.sv
design/bpsp_back.sv
design/box_plane_section_polygon.sv
bench/tb_box_plane_section_polygon.sv
